// ===== hw/rtl/ptbl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptbl_pkg
// Shared types and constants of the per-flow token bucket limiter.
// ----------------------------------------------------------------------------
package ptbl_pkg;

  localparam int FLOW_W          = 12;
  localparam int NUM_FLOWS       = 1 << FLOW_W;
  localparam int CNT_W           = FLOW_W + 1;
  localparam int PRUNE_INTERVAL  = 512;
  localparam int OPS_W           = 9;   // holds 0 .. PRUNE_INTERVAL-1
  localparam int TOKEN_FRAC_BITS = 16;
  localparam int BURST_W         = 16;
  localparam int TOK_W           = BURST_W + TOKEN_FRAC_BITS;
  localparam int TIME_W          = 48;
  localparam int RATE_W          = 48;
  localparam int IDLE_W          = 32;
  localparam int RATE_FRAC_BITS  = 32;
  localparam int CHUNK_W         = 16;
  localparam int NUM_CHUNKS      = RATE_W / CHUNK_W;
  localparam int STEP_W          = 2;
  localparam int PROD_W          = TIME_W + RATE_W;
  localparam int SHIFT_OUT       = RATE_FRAC_BITS - TOKEN_FRAC_BITS;
  localparam int CFG_IDX_W       = 2;
  localparam int IDLE_RESET      = 600000;

  localparam logic [CFG_IDX_W-1:0] REG_BURST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE  = 2'd2;

  localparam logic [TOK_W-1:0] TOKEN_ONE = TOK_W'(1) << TOKEN_FRAC_BITS;

  typedef struct packed {
    logic              valid;
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] refill_ms;
    logic [TIME_W-1:0] used_ms;
  } ptbl_entry_t;

  localparam int ENTRY_W = $bits(ptbl_entry_t);

  typedef struct packed {
    logic               start;
    logic [TOK_W-1:0]   tokens;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  delta;
    logic [RATE_W-1:0]  rate;
  } ptbl_refill_req_t;

  typedef struct packed {
    logic             done;
    logic [TOK_W-1:0] tokens;
  } ptbl_refill_rsp_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_SWEEP = 6'b100000
  } ptbl_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ptbl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptbl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptbl_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ptbl_refill.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptbl_refill
// Multi-cycle refill: elapsed time times rate, one 16-bit rate chunk per cycle,
// then saturate against the burst and clamp the new token count.
// ----------------------------------------------------------------------------
module ptbl_refill (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ptbl_pkg::ptbl_refill_req_t req,
  output ptbl_pkg::ptbl_refill_rsp_t      rsp
);

  logic                              busy_r, busy_nxt;
  logic [ptbl_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [ptbl_pkg::PROD_W-1:0]       acc_r, acc_nxt;
  logic [ptbl_pkg::TIME_W-1:0]       delta_r;
  logic [ptbl_pkg::RATE_W-1:0]       rate_r;
  logic [ptbl_pkg::TOK_W-1:0]        tok_r;
  logic [ptbl_pkg::BURST_W-1:0]      burst_r;
  logic                              done_r, done_nxt;
  logic [ptbl_pkg::TOK_W-1:0]        tok_out_r, tok_out_nxt;

  logic [ptbl_pkg::CHUNK_W-1:0]      chunk;
  logic [ptbl_pkg::TIME_W+ptbl_pkg::CHUNK_W-1:0] prod;
  logic [ptbl_pkg::PROD_W-1:0]       part;
  logic [ptbl_pkg::PROD_W-1:0]       cap32;
  logic [ptbl_pkg::TOK_W-1:0]        cap;
  logic [ptbl_pkg::TOK_W:0]          sum;

  always_comb begin
    case (step_r)
      2'd0:    chunk = rate_r[ptbl_pkg::CHUNK_W-1:0];
      2'd1:    chunk = rate_r[2*ptbl_pkg::CHUNK_W-1:ptbl_pkg::CHUNK_W];
      2'd2:    chunk = rate_r[3*ptbl_pkg::CHUNK_W-1:2*ptbl_pkg::CHUNK_W];
      default: chunk = '0;
    endcase
  end

  assign prod  = delta_r * chunk;
  assign part  = ptbl_pkg::PROD_W'(prod) << {step_r, 4'b0000};
  assign cap   = {burst_r, {ptbl_pkg::TOKEN_FRAC_BITS{1'b0}}};
  assign cap32 = ptbl_pkg::PROD_W'({burst_r, {ptbl_pkg::RATE_FRAC_BITS{1'b0}}});
  assign sum   = {1'b0, tok_r}
               + {1'b0, acc_r[ptbl_pkg::TOK_W+ptbl_pkg::SHIFT_OUT-1:ptbl_pkg::SHIFT_OUT]};

  always_comb begin
    busy_nxt    = busy_r;
    step_nxt    = step_r;
    acc_nxt     = acc_r;
    done_nxt    = 1'b0;
    tok_out_nxt = tok_out_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (step_r == ptbl_pkg::STEP_W'(ptbl_pkg::NUM_CHUNKS)) begin
        // product above the burst fills the bucket outright
        if (acc_r > cap32 || sum > {1'b0, cap}) begin
          tok_out_nxt = cap;
        end else begin
          tok_out_nxt = sum[ptbl_pkg::TOK_W-1:0];
        end
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        acc_nxt  = acc_r + part;
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    acc_r     <= acc_nxt;
    tok_out_r <= tok_out_nxt;
    if (req.start) begin
      delta_r <= req.delta;
      rate_r  <= req.rate;
      tok_r   <= req.tokens;
      burst_r <= req.burst;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.tokens = tok_out_r;

endmodule
`default_nettype wire

// ===== hw/rtl/per_flow_token_bucket_limiter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_flow_token_bucket_limiter_core
// Per-flow token bucket limiter over a 4096-entry bucket table.
// ----------------------------------------------------------------------------
// One request is in flight at a time. With limiting disabled (burst or rate
// zero) the answer is ready in the cycle after the transfer. Otherwise the
// answer comes from a table read-modify-write through the READ and WRITE
// states, with the MUL state between them when the bucket needs a refill (the
// refill multiplier works one 16-bit rate chunk per cycle). A new request can
// transfer in the cycle the answer appears. Every 512th enabled request is
// followed by an idle sweep over the table through its single read port,
// during which no request is taken. After reset a clearing pass writes every
// table entry before the first request is taken; configuration writes are
// taken at any time.
module per_flow_token_bucket_limiter_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ptbl_pkg::FLOW_W-1:0]        in_flow_key,
  input  wire logic [ptbl_pkg::TIME_W-1:0]        in_now_ms,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_allowed,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ptbl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ptbl_pkg::RATE_W-1:0]        cfg_data
);

  logic [ptbl_pkg::BURST_W-1:0] burst_capacity_r;
  logic [ptbl_pkg::RATE_W-1:0]  refill_rate_q32_r;
  logic [ptbl_pkg::IDLE_W-1:0]  idle_limit_ms_r;

  ptbl_pkg::ptbl_state_t        state_r, state_nxt;
  logic [ptbl_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         pend_r, pend_nxt;
  logic [ptbl_pkg::FLOW_W-1:0]  wa_r;
  logic [ptbl_pkg::FLOW_W-1:0]  key_r;
  logic [ptbl_pkg::TIME_W-1:0]  now_r;
  logic [ptbl_pkg::BURST_W-1:0] burst_r;
  logic [ptbl_pkg::RATE_W-1:0]  rate_r;
  logic [ptbl_pkg::IDLE_W-1:0]  idle_r;
  logic [ptbl_pkg::TOK_W-1:0]   tok_pre_r, tok_pre_nxt;
  logic [ptbl_pkg::TIME_W-1:0]  refill_r, refill_nxt;
  logic [ptbl_pkg::OPS_W-1:0]   ops_r, ops_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_allowed_r, out_allowed_nxt;

  logic                         in_xfer, enabled, allow;
  logic                         we;
  logic [ptbl_pkg::FLOW_W-1:0]  waddr, raddr;
  ptbl_pkg::ptbl_entry_t        wdata, rdata;
  logic [ptbl_pkg::ENTRY_W-1:0] rdata_raw;
  logic [ptbl_pkg::TIME_W-1:0]  idle_age;

  ptbl_pkg::ptbl_refill_req_t   rf_req;
  ptbl_pkg::ptbl_refill_rsp_t   rf_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_capacity_r  <= '0;
      refill_rate_q32_r <= '0;
      idle_limit_ms_r   <= ptbl_pkg::IDLE_W'(ptbl_pkg::IDLE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptbl_pkg::REG_BURST: burst_capacity_r  <= cfg_data[ptbl_pkg::BURST_W-1:0];
        ptbl_pkg::REG_RATE:  refill_rate_q32_r <= cfg_data;
        ptbl_pkg::REG_IDLE:  idle_limit_ms_r   <= cfg_data[ptbl_pkg::IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != ptbl_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;
  assign enabled  = (burst_capacity_r != '0) && (refill_rate_q32_r != '0);
  assign allow    = tok_pre_r >= ptbl_pkg::TOKEN_ONE;
  assign rdata    = ptbl_pkg::ptbl_entry_t'(rdata_raw);
  assign idle_age = now_r - rdata.used_ms;

  ptbl_ram #(
    .WIDTH (ptbl_pkg::ENTRY_W),
    .DEPTH (ptbl_pkg::NUM_FLOWS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  ptbl_refill u_refill (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rf_req),
    .rsp   (rf_rsp)
  );

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pend_nxt        = 1'b0;
    tok_pre_nxt     = tok_pre_r;
    refill_nxt      = refill_r;
    ops_nxt         = ops_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_allowed_nxt = out_allowed_r;
    we              = 1'b0;
    waddr           = key_r;
    wdata           = '0;
    raddr           = in_flow_key;
    rf_req.start    = 1'b0;
    rf_req.tokens   = rdata.tokens;
    rf_req.burst    = burst_r;
    rf_req.delta    = now_r - rdata.refill_ms;
    rf_req.rate     = rate_r;

    case (state_r)
      ptbl_pkg::ST_CLEAR: begin
        we      = 1'b1;
        waddr   = cnt_r[ptbl_pkg::FLOW_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ptbl_pkg::CNT_W'(ptbl_pkg::NUM_FLOWS - 1)) begin
          state_nxt = ptbl_pkg::ST_IDLE;
        end
      end
      ptbl_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (enabled) begin
            state_nxt = ptbl_pkg::ST_READ;
          end else begin
            out_valid_nxt   = 1'b1;
            out_allowed_nxt = 1'b1;
          end
        end
      end
      ptbl_pkg::ST_READ: begin
        if (!rdata.valid) begin
          tok_pre_nxt = {burst_r, {ptbl_pkg::TOKEN_FRAC_BITS{1'b0}}};
          refill_nxt  = now_r;
          state_nxt   = ptbl_pkg::ST_WRITE;
        end else if (now_r > rdata.refill_ms) begin
          rf_req.start = 1'b1;
          refill_nxt   = now_r;
          state_nxt    = ptbl_pkg::ST_MUL;
        end else begin
          tok_pre_nxt = rdata.tokens;
          refill_nxt  = rdata.refill_ms;
          state_nxt   = ptbl_pkg::ST_WRITE;
        end
      end
      ptbl_pkg::ST_MUL: begin
        if (rf_rsp.done) begin
          tok_pre_nxt = rf_rsp.tokens;
          state_nxt   = ptbl_pkg::ST_WRITE;
        end
      end
      ptbl_pkg::ST_WRITE: begin
        we                = 1'b1;
        wdata.valid       = 1'b1;
        wdata.tokens      = allow ? tok_pre_r - ptbl_pkg::TOKEN_ONE : tok_pre_r;
        wdata.refill_ms   = refill_r;
        wdata.used_ms     = now_r;
        out_valid_nxt     = 1'b1;
        out_allowed_nxt   = allow;
        if (ops_r == ptbl_pkg::OPS_W'(ptbl_pkg::PRUNE_INTERVAL - 1)) begin
          ops_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ptbl_pkg::ST_SWEEP;
        end else begin
          ops_nxt   = ops_r + 1'b1;
          state_nxt = ptbl_pkg::ST_IDLE;
        end
      end
      ptbl_pkg::ST_SWEEP: begin
        // read one entry a cycle, write back the previous one if it aged out
        raddr = cnt_r[ptbl_pkg::FLOW_W-1:0];
        if (cnt_r != ptbl_pkg::CNT_W'(ptbl_pkg::NUM_FLOWS)) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          state_nxt = ptbl_pkg::ST_IDLE;
        end
        if (pend_r && rdata.valid && now_r > rdata.used_ms
            && idle_age > ptbl_pkg::TIME_W'(idle_r)) begin
          we          = 1'b1;
          waddr       = wa_r;
          wdata       = rdata;
          wdata.valid = 1'b0;
        end
      end
      default: begin
        state_nxt = ptbl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptbl_pkg::ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      ops_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      ops_r       <= ops_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_allowed_r <= out_allowed_nxt;
    tok_pre_r     <= tok_pre_nxt;
    refill_r      <= refill_nxt;
    wa_r          <= cnt_r[ptbl_pkg::FLOW_W-1:0];
    // hold a snapshot of the request and the registers for its whole run
    if (in_xfer) begin
      key_r   <= in_flow_key;
      now_r   <= in_now_ms;
      burst_r <= burst_capacity_r;
      rate_r  <= refill_rate_q32_r;
      idle_r  <= idle_limit_ms_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_allowed = out_allowed_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ptbl_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptbl_checker
// Port-level checks of the limiter core, bound to the core module.
// ----------------------------------------------------------------------------
module ptbl_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic [ptbl_pkg::FLOW_W-1:0]    in_flow_key,
  input wire logic [ptbl_pkg::TIME_W-1:0]    in_now_ms,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           out_allowed,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [ptbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [ptbl_pkg::RATE_W-1:0]    cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_allowed))
    else $error("stalled result changed");

  // the clearing pass keeps requests out right after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during clearing pass");

  // no transfer in while a result waits stalled
  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !(out_valid && out_stall))
    else $error("request taken while result stalled");

  // a result taken with no new request leaves the slot empty
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
    else $error("result without a request");

endmodule

bind per_flow_token_bucket_limiter_core ptbl_checker u_ptbl_checker (.*);
`default_nettype wire
